>>> rtl/core/blw_pkg.sv
// Shared types and codes for the line pixel walker.
// No dependencies; imported by blw_setup and the top level.
package blw_pkg;

    // Request kinds carried on the input tuser bit
    typedef enum logic {
        REQ_START = 1'b0,
        REQ_NEXT  = 1'b1
    } req_type_t;

    // Orientation of a line against the local (major, minor) walk
    typedef struct packed {
        logic neg_x;   // screen x runs against the walk
        logic neg_y;   // screen y runs against the walk
        logic steep;   // major axis is y
    } line_flags_t;

endpackage

>>> rtl/core/blw_setup.sv
// Start-of-line decode: origin, final endpoint, axis lengths and orientation.
// Pure combinational; depends on blw_pkg for line_flags_t.
module blw_setup
    import blw_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic [COORD_BITS-1:0] origin_x,
    output logic [COORD_BITS-1:0] origin_y,
    output logic [COORD_BITS-1:0] endpt_x,
    output logic [COORD_BITS-1:0] endpt_y,
    output logic [COORD_BITS-1:0] major_len,
    output logic [COORD_BITS-1:0] minor_len,
    output line_flags_t           flags
);

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   dx_mag;
    logic [COORD_BITS:0]   dy_mag;
    logic                  dx_neg;
    logic                  dy_neg;
    logic                  swap_ends;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;

    // Signed deltas, one bit wider than a coordinate
    assign dx     = {1'b0, end_x} - {1'b0, start_x};
    assign dy     = {1'b0, end_y} - {1'b0, start_y};
    assign dx_neg = dx[COORD_BITS];
    assign dy_neg = dy[COORD_BITS];
    assign dx_mag = dx_neg ? (~dx + 1'b1) : dx;
    assign dy_mag = dy_neg ? (~dy + 1'b1) : dy;
    assign adx    = dx_mag[COORD_BITS-1:0];
    assign ady    = dy_mag[COORD_BITS-1:0];

    // Walk from the end point when both deltas go negative
    assign swap_ends = dx_neg && dy_neg;

    always_comb begin
        if (swap_ends) begin
            origin_x    = end_x;
            origin_y    = end_y;
            endpt_x     = start_x;
            endpt_y     = start_y;
            flags.neg_x = 1'b0;
            flags.neg_y = 1'b0;
        end else begin
            origin_x    = start_x;
            origin_y    = start_y;
            endpt_x     = end_x;
            endpt_y     = end_y;
            flags.neg_x = dx_neg;
            flags.neg_y = dy_neg;
        end
        flags.steep = ady > adx;
        major_len   = flags.steep ? ady : adx;
        minor_len   = flags.steep ? adx : ady;
    end

endmodule

>>> rtl/core/bresenham_line_pixel_walker_unit.sv
// Top level of the line pixel walker: walk state, error update, output register.
// Depends on blw_pkg and blw_setup.
//
//  channel | dir | tdata (low bit up)                        | tuser        | tlast
//  s_      | in  | start_x, start_y, end_x, end_y            | req_type     | -
//  m_      | out | pixel_x, pixel_y                          | pixel_valid  | last_pixel
//
// One beat in gives one registered beat out in the next cycle, at a sustained one beat per clock while m_tready holds.
// The error subtract/add and the one-step position update sit between the walk
// registers and the output register; that path sets the clock.
// aresetn (synchronous, active low) clears the active line and the output valid.
// A stalled output holds its beat; s_tready follows the output register and m_tready only.
module bresenham_line_pixel_walker_unit
    import blw_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // start_x, start_y, end_x, end_y, zero fill to bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // req_type
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // pixel_x, pixel_y, zero fill to bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    // pixel_valid
    output logic [0:0]                            m_tuser,
    output logic                                  m_tlast
);

    localparam int CB    = COORD_BITS;
    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;
    localparam int ERR_W = COORD_BITS + 3;

    // Input fields
    logic [CB-1:0] start_x;
    logic [CB-1:0] start_y;
    logic [CB-1:0] end_x;
    logic [CB-1:0] end_y;
    req_type_t     req_type;
    logic          accept;

    assign start_x  = s_tdata[CB-1:0];
    assign start_y  = s_tdata[2*CB-1:CB];
    assign end_x    = s_tdata[3*CB-1:2*CB];
    assign end_y    = s_tdata[4*CB-1:3*CB];
    assign req_type = req_type_t'(s_tuser[0]);

    // Start decode
    logic [CB-1:0] set_origin_x;
    logic [CB-1:0] set_origin_y;
    logic [CB-1:0] set_endpt_x;
    logic [CB-1:0] set_endpt_y;
    logic [CB-1:0] set_major;
    logic [CB-1:0] set_minor;
    line_flags_t   set_flags;

    blw_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .origin_x  (set_origin_x),
        .origin_y  (set_origin_y),
        .endpt_x   (set_endpt_x),
        .endpt_y   (set_endpt_y),
        .major_len (set_major),
        .minor_len (set_minor),
        .flags     (set_flags)
    );

    // Walk state
    logic                    active_reg,    active_next;
    line_flags_t             flags_reg,     flags_next;
    logic [CB-1:0]           major_len_reg, major_len_next;
    logic [CB-1:0]           minor_len_reg, minor_len_next;
    logic [CB-1:0]           major_pos_reg, major_pos_next;
    logic signed [ERR_W-1:0] error_reg,     error_next;
    logic [CB-1:0]           pos_x_reg,     pos_x_next;
    logic [CB-1:0]           pos_y_reg,     pos_y_next;
    logic [CB-1:0]           endpt_x_reg,   endpt_x_next;
    logic [CB-1:0]           endpt_y_reg,   endpt_y_next;

    // Output register
    logic          m_valid_reg;
    logic [CB-1:0] out_x_reg,     out_x_next;
    logic [CB-1:0] out_y_reg,     out_y_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_last_reg,  out_last_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // One walk step: error update, minor step decision, end detection
    logic [CB:0]             step_pos;
    logic signed [ERR_W-1:0] err_sub;
    logic signed [ERR_W-1:0] twice_minor;
    logic signed [ERR_W-1:0] twice_major;
    logic                    minor_step;
    logic                    at_end;
    logic                    step_x;
    logic                    step_y;
    logic [CB-1:0]           x_stepped;
    logic [CB-1:0]           y_stepped;

    assign step_pos    = {1'b0, major_pos_reg} + 1'b1;
    assign twice_minor = $signed({2'b00, minor_len_reg, 1'b0});
    assign twice_major = $signed({2'b00, major_len_reg, 1'b0});
    assign err_sub     = error_reg - twice_minor;
    assign minor_step  = err_sub <= 0;
    assign at_end      = step_pos >= {1'b0, major_len_reg};
    assign step_x      = !flags_reg.steep || minor_step;
    assign step_y      = flags_reg.steep || minor_step;
    assign x_stepped   = flags_reg.neg_x ? pos_x_reg - 1'b1 : pos_x_reg + 1'b1;
    assign y_stepped   = flags_reg.neg_y ? pos_y_reg - 1'b1 : pos_y_reg + 1'b1;

    // Next state and result for the beat on the input
    always_comb begin
        active_next    = active_reg;
        flags_next     = flags_reg;
        major_len_next = major_len_reg;
        minor_len_next = minor_len_reg;
        major_pos_next = major_pos_reg;
        error_next     = error_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        endpt_x_next   = endpt_x_reg;
        endpt_y_next   = endpt_y_reg;
        out_x_next     = '0;
        out_y_next     = '0;
        out_valid_next = 1'b0;
        out_last_next  = 1'b0;

        priority if (req_type == REQ_START) begin
            flags_next     = set_flags;
            major_len_next = set_major;
            minor_len_next = set_minor;
            major_pos_next = '0;
            error_next     = $signed({3'b000, set_major});
            pos_x_next     = set_origin_x;
            pos_y_next     = set_origin_y;
            endpt_x_next   = set_endpt_x;
            endpt_y_next   = set_endpt_y;
            active_next    = set_major != '0;
            out_x_next     = set_origin_x;
            out_y_next     = set_origin_y;
            out_valid_next = 1'b1;
            out_last_next  = set_major == '0;
        end else if (active_reg) begin
            error_next     = minor_step ? err_sub + twice_major : err_sub;
            out_valid_next = 1'b1;
            if (at_end) begin
                // Finish on the exact endpoint
                active_next    = 1'b0;
                major_pos_next = major_len_reg;
                pos_x_next     = endpt_x_reg;
                pos_y_next     = endpt_y_reg;
                out_x_next     = endpt_x_reg;
                out_y_next     = endpt_y_reg;
                out_last_next  = 1'b1;
            end else begin
                major_pos_next = step_pos[CB-1:0];
                pos_x_next     = step_x ? x_stepped : pos_x_reg;
                pos_y_next     = step_y ? y_stepped : pos_y_reg;
                out_x_next     = step_x ? x_stepped : pos_x_reg;
                out_y_next     = step_y ? y_stepped : pos_y_reg;
            end
        end else begin
            // No line: hand back an invalid pixel
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                active_reg  <= active_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Walk payload and output beat, loaded on each accepted beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            flags_reg     <= flags_next;
            major_len_reg <= major_len_next;
            minor_len_reg <= minor_len_next;
            major_pos_reg <= major_pos_next;
            error_reg     <= error_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            endpt_x_reg   <= endpt_x_next;
            endpt_y_reg   <= endpt_y_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = OUT_W'({out_y_reg, out_x_reg});
    assign m_tuser[0] = out_valid_reg;
    assign m_tlast    = out_last_reg;

    // Checks on the walk logic
    a_invalid_is_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> !m_tlast && m_tdata == '0)
        else $error("invalid pixel beat carries data");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !active_reg)
        else $error("line still active after its last pixel");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> major_pos_reg < major_len_reg)
        else $error("walk position past line length");

    a_point_line: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && req_type == REQ_START && start_x == end_x && start_y == end_y
        |=> m_tvalid && m_tlast && m_tuser[0] && !active_reg)
        else $error("single point line not finished at once");

endmodule

>>> test/tb_bresenham_line_pixel_walker_unit.sv
// Testbench for bresenham_line_pixel_walker_unit: a line-walk predictor checks every output beat.
// It drives directed and random line requests with random stalls on both channels.
// Depends on blw_pkg and the walker RTL.
module tb_bresenham_line_pixel_walker_unit;
    import blw_pkg::*;

    localparam int COORD_W    = 12;
    localparam int COORD_MAX  = (1 << COORD_W) - 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int STALL_LEN  = 120;
    localparam int TAIL_WAIT  = 8;
    localparam int ITEM_GOAL  = 700;

    typedef logic [COORD_W-1:0] coord_t;

    // One output pixel as seen on the master side
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   valid;
        logic   last;
    } pixel_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [4*COORD_W-1:0] s_tdata;   // start_x, start_y, end_x, end_y
    logic [0:0]           s_tuser;   // req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [2*COORD_W-1:0] m_tdata;   // pixel_x, pixel_y
    logic [0:0]           m_tuser;   // pixel_valid
    logic                 m_tlast;

    bresenham_line_pixel_walker_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Walk state of the predictor, cleared like the block after reset
    bit walk_active  = 1'b0;
    int walk_origin_x = 0;
    int walk_origin_y = 0;
    bit walk_neg_x   = 1'b0;
    bit walk_neg_y   = 1'b0;
    bit walk_steep   = 1'b0;
    int walk_major_len = 0;
    int walk_minor_len = 0;
    int walk_major_pos = 0;
    int walk_minor_pos = 0;
    int walk_error     = 0;

    pixel_t pending_pixels[$];

    int error_count    = 0;
    int requests_sent  = 0;
    int pixels_checked = 0;
    int lines_finished = 0;
    int invalid_seen   = 0;

    bit          send_idle_on   = 1'b1;
    bit          recv_idle_on   = 1'b1;
    int unsigned ready_hold_req = 0;
    int unsigned stall_left     = 0;
    int unsigned quiet_cycles   = 0;

    // Free-running clock
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic coord_t rand_coord();
        return coord_t'($urandom_range(0, COORD_MAX));
    endfunction

    // Pick a coordinate within span of base, mirrored back if it leaves the range
    function automatic coord_t nudge_coord(coord_t base, int span);
        int d;
        int v;
        d = int'($urandom_range(0, 2 * span)) - span;
        v = int'(base) + d;
        if (v < 0 || v > COORD_MAX)
            v = int'(base) - d;
        return coord_t'(v);
    endfunction

    // Map a local (major, minor) position back to screen coordinates
    function automatic pixel_t place_pixel(int mj, int mn, bit last);
        pixel_t px;
        int ax;
        int ay;
        ax = walk_steep ? mn : mj;
        ay = walk_steep ? mj : mn;
        px.x     = coord_t'(walk_neg_x ? walk_origin_x - ax : walk_origin_x + ax);
        px.y     = coord_t'(walk_neg_y ? walk_origin_y - ay : walk_origin_y + ay);
        px.valid = 1'b1;
        px.last  = last;
        return px;
    endfunction

    // Advance the line walk by one request and return the pixel it emits
    function automatic pixel_t walk_predict(req_type_t kind, coord_t sx, coord_t sy,
                                            coord_t ex, coord_t ey);
        pixel_t px;
        int dx;
        int dy;
        int adx;
        int ady;
        px = '0;
        if (kind == REQ_START) begin
            dx = int'(ex) - int'(sx);
            dy = int'(ey) - int'(sy);
            if (dx < 0 && dy < 0) begin
                // both deltas negative: walk from the far end, no mirroring
                walk_origin_x = int'(ex);
                walk_origin_y = int'(ey);
                walk_neg_x = 1'b0;
                walk_neg_y = 1'b0;
                adx = -dx;
                ady = -dy;
            end else begin
                walk_origin_x = int'(sx);
                walk_origin_y = int'(sy);
                walk_neg_x = (dx < 0);
                walk_neg_y = (dy < 0);
                adx = (dx < 0) ? -dx : dx;
                ady = (dy < 0) ? -dy : dy;
            end
            walk_steep     = (ady > adx);
            walk_major_len = walk_steep ? ady : adx;
            walk_minor_len = walk_steep ? adx : ady;
            walk_major_pos = 0;
            walk_minor_pos = 0;
            walk_error     = walk_major_len;
            if (walk_major_len == 0) begin
                walk_active = 1'b0;
                px = place_pixel(walk_major_len, walk_minor_len, 1'b1);
            end else begin
                walk_active = 1'b1;
                px = place_pixel(0, 0, 1'b0);
            end
        end else if (walk_active) begin
            walk_major_pos++;
            walk_error -= 2 * walk_minor_len;
            if (walk_error <= 0) begin
                walk_minor_pos++;
                walk_error += 2 * walk_major_len;
            end
            if (walk_major_pos >= walk_major_len) begin
                // snap the final pixel to the exact endpoint
                walk_active    = 1'b0;
                walk_major_pos = walk_major_len;
                walk_minor_pos = walk_minor_len;
                px = place_pixel(walk_major_len, walk_minor_len, 1'b1);
            end else begin
                px = place_pixel(walk_major_pos, walk_minor_pos, 1'b0);
            end
        end
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Compare one output beat with the oldest expected pixel
    task automatic check_pixel();
        pixel_t want;
        if (pending_pixels.size() == 0) begin
            report_mismatch("beat with nothing expected, tdata", int'(m_tdata), 0);
            return;
        end
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (m_tdata[COORD_W-1:0] !== want.x)
            report_mismatch("pixel_x", int'(m_tdata[COORD_W-1:0]), int'(want.x));
        if (m_tdata[2*COORD_W-1:COORD_W] !== want.y)
            report_mismatch("pixel_y", int'(m_tdata[2*COORD_W-1:COORD_W]), int'(want.y));
        if (m_tuser[0] !== want.valid)
            report_mismatch("pixel_valid", int'(m_tuser[0]), int'(want.valid));
        if (m_tlast !== want.last)
            report_mismatch("last_pixel", int'(m_tlast), int'(want.last));
        if (want.last)
            lines_finished++;
        if (!want.valid)
            invalid_seen++;
    endtask

    // Check every accepted output beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_pixel();
    end

    // Drive m_tready: random gaps, or a long hold when a test asks for one
    always @(posedge aclk) begin
        int unsigned gap;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (ready_hold_req != 0) begin
            stall_left = ready_hold_req - 1;
            ready_hold_req = 0;
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            gap = recv_idle_on ? pick_gap() : 0;
            if (gap == 0) begin
                m_tready <= 1'b1;
            end else begin
                stall_left = gap - 1;
                m_tready <= 1'b0;
            end
        end
    end

    // End the run if neither channel moves a beat for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Offer one request, wait for the handshake, log its expected pixel, then idle for a random gap, possibly none
    task automatic send_request(input req_type_t kind, input coord_t sx, input coord_t sy,
                                input coord_t ex, input coord_t ey, output pixel_t predicted);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {ey, ex, sy, sx};
        do @(posedge aclk); while (!s_tready);
        predicted = walk_predict(kind, sx, sy, ex, ey);
        pending_pixels.push_back(predicted);
        requests_sent++;
        gap = send_idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_next(output pixel_t predicted);
        send_request(REQ_NEXT, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     predicted);
    endtask

    // Start a line and request pixels until its endpoint comes out
    task automatic walk_line(input coord_t sx, input coord_t sy, input coord_t ex,
                             input coord_t ey);
        pixel_t p;
        send_request(REQ_START, sx, sy, ex, ey, p);
        while (!p.last)
            send_next(p);
    endtask

    // Drop valid and hold until every expected pixel has been seen
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_next_without_line();
        pixel_t p;
        send_next(p);
        send_next(p);
    endtask

    task automatic test_single_point_lines();
        pixel_t p;
        walk_line(12'd0, 12'd0, 12'd0, 12'd0);
        walk_line(12'hfff, 12'hfff, 12'hfff, 12'hfff);
        send_next(p);
    endtask

    task automatic test_walk_directions();
        pixel_t p;
        // flat line, then one request past its end
        walk_line(12'd0, 12'd0, 12'd2, 12'd0);
        send_next(p);
        // both deltas negative
        walk_line(12'hfff, 12'hfff, 12'hffd, 12'hffe);
        // steep with mirrored y
        walk_line(12'd10, 12'hfff, 12'd11, 12'hffc);
        // mirrored x only
        walk_line(12'hfff, 12'd0, 12'hffd, 12'd1);
    endtask

    task automatic test_restart_mid_line();
        pixel_t p;
        send_request(REQ_START, 12'd0, 12'd0, 12'hfff, 12'hfff, p);
        send_next(p);
        send_request(REQ_START, 12'hfff, 12'd0, 12'd0, 12'hfff, p);
        send_next(p);
        walk_line(12'd5, 12'd5, 12'd5, 12'd6);
    endtask

    // Hold the output off while the sender keeps offering beats
    task automatic test_output_stall();
        send_idle_on = 1'b0;
        ready_hold_req = STALL_LEN;
        walk_line(12'd100, 12'd200, 12'd130, 12'd205);
        send_idle_on = 1'b1;
        drain_results();
    endtask

    // Let the block empty out completely between two lines
    task automatic test_sender_pause();
        walk_line(12'd300, 12'd40, 12'd296, 12'd49);
        drain_results();
        walk_line(12'd4000, 12'd8, 12'd4011, 12'd1);
    endtask

    // Mostly complete short lines with random ends, plus abandoned long lines and noise
    task automatic test_random_walks();
        pixel_t p;
        int     mode;
        int     steps;
        int     span;
        coord_t sx;
        coord_t sy;
        while (requests_sent < ITEM_GOAL) begin
            send_idle_on = ($urandom_range(0, 4) != 0);
            recv_idle_on = ($urandom_range(0, 4) != 0);
            mode = $urandom_range(0, 99);
            if (mode < 75) begin
                span = ($urandom_range(0, 2) == 0) ? 2 : 24;
                sx = rand_coord();
                sy = rand_coord();
                walk_line(sx, sy, nudge_coord(sx, span), nudge_coord(sy, span));
                if ($urandom_range(0, 3) == 0)
                    send_next(p);
            end else if (mode < 90) begin
                steps = $urandom_range(0, 12);
                send_request(REQ_START, rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), p);
                repeat (steps) begin
                    if (!p.last)
                        send_next(p);
                end
            end else begin
                send_request(req_type_t'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), p);
            end
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_START;

        // Hold reset from time zero, then release it
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_next_without_line();
        test_single_point_lines();
        test_walk_directions();
        test_restart_mid_line();
        test_output_stall();
        test_sender_pause();
        test_random_walks();

        drain_results();
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("Sent %0d line requests; checked %0d pixels over %0d finished lines,",
                 requests_sent, pixels_checked, lines_finished);
        $display("%0d requests with no line, output stalls and restarts mid-line included.",
                 invalid_seen);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
